// ===== src/crbw_pkg.sv =====
package crbw_pkg;

	// Point store geometry.
	localparam int MAX_POINTS = 64;
	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam int SPAN_W = 6;
	localparam int CMP_W = (CW > SPAN_W) ? CW : SPAN_W;

	// Field and datapath widths.
	localparam int PW = 18;
	localparam int PROD_W = 2 * PW;
	localparam int SUM_W = PW + 1;
	localparam int AIN_W = PROD_W + 1;
	localparam int ANG_W = 18;
	localparam int BRG_W = 16;
	localparam int WID_W = 15;

	// Arctangent unit: working width, angle width and normalization limits.
	localparam int AT_W = 44;
	localparam int Z_W = 34;
	localparam int STEPS = 28;
	localparam int STEP_W = 5;
	localparam logic signed [AT_W-1:0] NORM_TOP = 44'sd1 <<< 40;
	localparam logic signed [AT_W-1:0] NORM_COARSE = 44'sd1 <<< 32;
	localparam logic signed [Z_W-1:0] ANG_PI = 34'sd1 <<< 31;
	localparam logic signed [Z_W-1:0] ANG_HALF = 34'sd32768;

	// Square root: radicand and root widths.
	localparam int SQ_W = PROD_W;
	localparam int ROOT_W = 18;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic wr_en;
		logic [AW-1:0] wr_addr;
		logic rd_en;
		logic [AW-1:0] rd_j;
		logic [AW-1:0] rd_k;
		logic mul_en;
		logic sum_en;
		logic diag;
		logic init;
		logic pair_start;
		logic cmp_en;
		logic first;
		logic fin_start;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic ang_done;
		logic fin_done;
	} sts_t;

	// Arctangent of 2^-i with pi equal to 2^31.
	function automatic logic [29:0] atan_tab(input logic [STEP_W-1:0] i);
		logic [29:0] v;
		unique case (i)
			5'd0: v = 30'h20000000;
			5'd1: v = 30'h12E4051E;
			5'd2: v = 30'h09FB385B;
			5'd3: v = 30'h051111D4;
			5'd4: v = 30'h028B0D43;
			5'd5: v = 30'h0145D7E1;
			5'd6: v = 30'h00A2F61E;
			5'd7: v = 30'h00517C55;
			5'd8: v = 30'h0028BE53;
			5'd9: v = 30'h00145F2F;
			5'd10: v = 30'h000A2F98;
			5'd11: v = 30'h000517CC;
			5'd12: v = 30'h00028BE6;
			5'd13: v = 30'h000145F3;
			5'd14: v = 30'h0000A2FA;
			5'd15: v = 30'h0000517D;
			5'd16: v = 30'h000028BE;
			5'd17: v = 30'h0000145F;
			5'd18: v = 30'h00000A30;
			5'd19: v = 30'h00000518;
			5'd20: v = 30'h0000028C;
			5'd21: v = 30'h00000146;
			5'd22: v = 30'h000000A3;
			5'd23: v = 30'h00000051;
			5'd24: v = 30'h00000029;
			5'd25: v = 30'h00000014;
			5'd26: v = 30'h0000000A;
			5'd27: v = 30'h00000005;
			default: v = 30'h0;
		endcase
		return v;
	endfunction

endpackage

// ===== src/crbw_atan.sv =====
module crbw_atan (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic signed [crbw_pkg::AIN_W-1:0] y_in,
	input logic signed [crbw_pkg::AIN_W-1:0] x_in,
	output logic done,
	output logic signed [crbw_pkg::ANG_W-1:0] angle
);

	localparam logic [1:0] A_IDLE = 2'd0;
	localparam logic [1:0] A_NORM = 2'd1;
	localparam logic [1:0] A_ROT = 2'd2;

	logic [1:0] st_q;
	logic signed [crbw_pkg::AT_W-1:0] x_q, y_q;
	logic signed [crbw_pkg::Z_W-1:0] z_q;
	logic [crbw_pkg::STEP_W-1:0] i_q;
	logic done_q;
	logic signed [crbw_pkg::ANG_W-1:0] ang_q;

	logic signed [crbw_pkg::AT_W-1:0] xe, ye, ay, mag;
	logic signed [crbw_pkg::AT_W-1:0] xsh, ysh, xn, yn;
	logic signed [crbw_pkg::Z_W-1:0] tab, zn, zr;

	// Sign-extended operands and the larger magnitude of the working vector.
	assign xe = crbw_pkg::AT_W'(x_in);
	assign ye = crbw_pkg::AT_W'(y_in);
	assign ay = (y_q < 0) ? -y_q : y_q;
	assign mag = (x_q > ay) ? x_q : ay;

	// One vectoring rotation step.
	assign xsh = x_q >>> i_q;
	assign ysh = y_q >>> i_q;
	assign tab = signed'({4'b0, crbw_pkg::atan_tab(i_q)});
	always_comb begin
		xn = x_q;
		yn = y_q;
		zn = z_q;
		if (y_q > 0) begin
			xn = x_q + ysh;
			yn = y_q - xsh;
			zn = z_q + tab;
		end else if (y_q < 0) begin
			xn = x_q - ysh;
			yn = y_q + xsh;
			zn = z_q - tab;
		end
	end
	assign zr = zn + crbw_pkg::ANG_HALF;

	// Sequencer: fold into the right half plane, normalize, then rotate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= A_IDLE;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				A_IDLE: begin
					if (start) begin
						if (x_in == 0 && y_in == 0) begin
							done_q <= 1'b1;
						end else begin
							st_q <= A_NORM;
						end
					end
				end
				A_NORM: begin
					if (mag < crbw_pkg::NORM_COARSE) begin
					end else if (mag >= crbw_pkg::NORM_TOP) begin
						st_q <= A_ROT;
						i_q <= '0;
					end
				end
				A_ROT: begin
					if (i_q == crbw_pkg::STEP_W'(crbw_pkg::STEPS - 1)) begin
						st_q <= A_IDLE;
						done_q <= 1'b1;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				default: st_q <= A_IDLE;
			endcase
		end
	end

	// Working registers of the vector and the angle accumulator.
	always_ff @(posedge clk) begin
		unique case (st_q)
			A_IDLE: begin
				if (start) begin
					if (x_in == 0 && y_in == 0) begin
						ang_q <= '0;
					end else if (x_in < 0) begin
						x_q <= -xe;
						y_q <= -ye;
						z_q <= (y_in >= 0) ? crbw_pkg::ANG_PI : -crbw_pkg::ANG_PI;
					end else begin
						x_q <= xe;
						y_q <= ye;
						z_q <= '0;
					end
				end
			end
			A_NORM: begin
				if (mag < crbw_pkg::NORM_COARSE) begin
					x_q <= x_q <<< 8;
					y_q <= y_q <<< 8;
				end else if (mag < crbw_pkg::NORM_TOP) begin
					x_q <= x_q <<< 1;
					y_q <= y_q <<< 1;
				end
			end
			A_ROT: begin
				x_q <= xn;
				y_q <= yn;
				z_q <= zn;
				if (i_q == crbw_pkg::STEP_W'(crbw_pkg::STEPS - 1)) begin
					ang_q <= zr[crbw_pkg::Z_W-1:16];
				end
			end
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign angle = ang_q;

endmodule

// ===== src/crbw_isqrt.sv =====
module crbw_isqrt (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [crbw_pkg::SQ_W-1:0] radicand,
	output logic done,
	output logic [crbw_pkg::ROOT_W-1:0] root
);

	logic run_q, done_q;
	logic [crbw_pkg::SQ_W-1:0] v_q, r_q, bit_q;
	logic [crbw_pkg::ROOT_W-1:0] root_q;
	logic [crbw_pkg::SQ_W:0] trial;
	logic [crbw_pkg::SQ_W-1:0] vn, rn;
	logic fits;

	// One result bit per cycle, two radicand bits per step.
	assign trial = {1'b0, r_q} + {1'b0, bit_q};
	assign fits = {1'b0, v_q} >= trial;
	assign vn = fits ? v_q - trial[crbw_pkg::SQ_W-1:0] : v_q;
	assign rn = fits ? (r_q >> 1) + bit_q : (r_q >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && bit_q[0]) begin
				run_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Remainder, partial root and round to nearest on the last step.
	always_ff @(posedge clk) begin
		if (start) begin
			v_q <= radicand;
			r_q <= '0;
			bit_q <= crbw_pkg::SQ_W'(1) << (crbw_pkg::SQ_W - 2);
		end else if (run_q) begin
			v_q <= vn;
			r_q <= rn;
			bit_q <= bit_q >> 2;
			if (bit_q[0]) begin
				root_q <= rn[crbw_pkg::ROOT_W-1:0] + crbw_pkg::ROOT_W'(vn > rn);
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

// ===== src/crbw_dp.sv =====
module crbw_dp (
	input logic clk,
	input logic arst_n,
	input crbw_pkg::cmd_t cmd,
	output crbw_pkg::sts_t sts,
	input logic signed [crbw_pkg::PW-1:0] point_x,
	input logic signed [crbw_pkg::PW-1:0] point_y,
	output logic [crbw_pkg::ROOT_W-1:0] min_range,
	output logic signed [crbw_pkg::BRG_W-1:0] bearing,
	output logic [crbw_pkg::WID_W-1:0] angular_width
);

	logic [2*crbw_pkg::PW-1:0] mem [crbw_pkg::MAX_POINTS];
	logic [2*crbw_pkg::PW-1:0] rdj_s1, rdk_s1;
	logic signed [crbw_pkg::PW-1:0] xj, yj, xk, yk;
	logic signed [crbw_pkg::PROD_W-1:0] pxx_s2, pyy_s2, pxy_s2, pyx_s2;
	logic signed [crbw_pkg::SUM_W-1:0] sx_s2, sy_s2;
	logic signed [crbw_pkg::AIN_W-1:0] cross_s3, dot_s3, cross_c, dot_c;
	logic [crbw_pkg::SQ_W-1:0] min_q;
	logic signed [crbw_pkg::ANG_W-1:0] best_q, ang;
	logic signed [crbw_pkg::SUM_W-1:0] bx_q, by_q;
	logic signed [crbw_pkg::AIN_W-1:0] at_y, at_x;
	logic at_start, at_done, sq_done;
	logic brg_done_q, sq_done_q;
	logic [crbw_pkg::ROOT_W-1:0] root;

	// Point store: one write port, two registered read ports.
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[cmd.wr_addr] <= {point_x, point_y};
		end
		if (cmd.rd_en) begin
			rdj_s1 <= mem[cmd.rd_j];
			rdk_s1 <= mem[cmd.rd_k];
		end
	end

	assign xj = signed'(rdj_s1[2*crbw_pkg::PW-1:crbw_pkg::PW]);
	assign yj = signed'(rdj_s1[crbw_pkg::PW-1:0]);
	assign xk = signed'(rdk_s1[2*crbw_pkg::PW-1:crbw_pkg::PW]);
	assign yk = signed'(rdk_s1[crbw_pkg::PW-1:0]);

	// Four products of the pair and its vector sum.
	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			pxx_s2 <= xj * xk;
			pyy_s2 <= yj * yk;
			pxy_s2 <= xj * yk;
			pyx_s2 <= yj * xk;
			sx_s2 <= crbw_pkg::SUM_W'(xj) + crbw_pkg::SUM_W'(xk);
			sy_s2 <= crbw_pkg::SUM_W'(yj) + crbw_pkg::SUM_W'(yk);
		end
	end

	// Cross and dot products; the dot of a point with itself is its squared range.
	assign cross_c = crbw_pkg::AIN_W'(pxy_s2) - crbw_pkg::AIN_W'(pyx_s2);
	assign dot_c = crbw_pkg::AIN_W'(pxx_s2) + crbw_pkg::AIN_W'(pyy_s2);
	always_ff @(posedge clk) begin
		if (cmd.sum_en) begin
			cross_s3 <= cross_c;
			dot_s3 <= dot_c;
		end
		if (cmd.init) begin
			min_q <= '1;
		end else if (cmd.sum_en && cmd.diag && dot_c[crbw_pkg::SQ_W-1:0] < min_q) begin
			min_q <= dot_c[crbw_pkg::SQ_W-1:0];
		end
	end

	// Keep the widest pair; a tie keeps the earlier pair.
	always_ff @(posedge clk) begin
		if (cmd.cmp_en && (cmd.first || ang > best_q)) begin
			best_q <= ang;
			bx_q <= sx_s2;
			by_q <= sy_s2;
		end
	end

	// Shared arctangent unit: pair angles, then the bearing of the sum vector.
	assign at_start = cmd.pair_start | cmd.fin_start;
	assign at_y = cmd.fin_start ? crbw_pkg::AIN_W'(by_q) : cross_s3;
	assign at_x = cmd.fin_start ? crbw_pkg::AIN_W'(bx_q) : dot_s3;

	crbw_atan u_atan (
		.clk(clk),
		.arst_n(arst_n),
		.start(at_start),
		.y_in(at_y),
		.x_in(at_x),
		.done(at_done),
		.angle(ang)
	);

	crbw_isqrt u_isqrt (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.fin_start),
		.radicand(min_q),
		.done(sq_done),
		.root(root)
	);

	// Completion flags of the final phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			brg_done_q <= 1'b0;
			sq_done_q <= 1'b0;
		end else if (cmd.fin_start) begin
			brg_done_q <= 1'b0;
			sq_done_q <= 1'b0;
		end else begin
			if (at_done) begin
				brg_done_q <= 1'b1;
			end
			if (sq_done) begin
				sq_done_q <= 1'b1;
			end
		end
	end

	assign sts.ang_done = at_done;
	assign sts.fin_done = brg_done_q & sq_done_q;

	// Result words.
	assign min_range = root;
	assign bearing = ang[crbw_pkg::BRG_W-1:0];
	always_comb begin
		if (best_q < 0) begin
			angular_width = '0;
		end else if (best_q > crbw_pkg::ANG_W'(32767)) begin
			angular_width = '1;
		end else begin
			angular_width = best_q[crbw_pkg::WID_W-1:0];
		end
	end

endmodule

// ===== src/crbw_ctrl.sv =====
module crbw_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic last_point,
	input logic cfg_we,
	input logic [crbw_pkg::SPAN_W-1:0] cfg_wdata,
	input crbw_pkg::sts_t sts,
	output crbw_pkg::cmd_t cmd,
	output logic busy,
	output logic done
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD = 4'd1;
	localparam logic [3:0] S_MUL = 4'd2;
	localparam logic [3:0] S_SUM = 4'd3;
	localparam logic [3:0] S_AST = 4'd4;
	localparam logic [3:0] S_AWT = 4'd5;
	localparam logic [3:0] S_CMP = 4'd6;
	localparam logic [3:0] S_FST = 4'd7;
	localparam logic [3:0] S_FWT = 4'd8;

	logic [3:0] state_q;
	logic [crbw_pkg::SPAN_W-1:0] span_q;
	logic [crbw_pkg::CW-1:0] count_q;
	logic ovf_q, first_q, done_q;
	logic [crbw_pkg::AW-1:0] j_q, k_q, lastidx_q;
	logic acc, wr_ok, ovf_new, ok;
	logic [crbw_pkg::CW-1:0] n_new, n_m1;

	// Word acceptance and the size check made on the last point.
	assign acc = (state_q == S_IDLE) && start;
	assign wr_ok = !ovf_q && (count_q < crbw_pkg::CW'(crbw_pkg::MAX_POINTS));
	assign n_new = count_q + crbw_pkg::CW'(wr_ok);
	assign n_m1 = n_new - 1'b1;
	assign ovf_new = ovf_q | !wr_ok;
	assign ok = !ovf_new && (n_new != '0)
		&& (crbw_pkg::CMP_W'(n_m1) <= crbw_pkg::CMP_W'(span_q));

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			span_q <= '1;
		end else if (cfg_we) begin
			span_q <= cfg_wdata;
		end
	end

	// Main sequencer: load, pair loop, final bearing and root.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			ovf_q <= 1'b0;
			first_q <= 1'b0;
			done_q <= 1'b0;
			j_q <= '0;
			k_q <= '0;
			lastidx_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						if (last_point) begin
							count_q <= '0;
							ovf_q <= 1'b0;
							if (ok) begin
								lastidx_q <= n_m1[crbw_pkg::AW-1:0];
								j_q <= '0;
								k_q <= '0;
								first_q <= 1'b1;
								state_q <= S_RD;
							end
						end else begin
							count_q <= n_new;
							ovf_q <= ovf_new;
						end
					end
				end
				S_RD: state_q <= S_MUL;
				S_MUL: state_q <= S_SUM;
				S_SUM: state_q <= S_AST;
				S_AST: state_q <= S_AWT;
				S_AWT: begin
					if (sts.ang_done) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					first_q <= 1'b0;
					if (k_q == lastidx_q) begin
						k_q <= '0;
						if (j_q == lastidx_q) begin
							state_q <= S_FST;
						end else begin
							j_q <= j_q + 1'b1;
							state_q <= S_RD;
						end
					end else begin
						k_q <= k_q + 1'b1;
						state_q <= S_RD;
					end
				end
				S_FST: state_q <= S_FWT;
				S_FWT: begin
					if (sts.fin_done) begin
						done_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Commands to the datapath.
	always_comb begin
		cmd = '0;
		cmd.wr_en = acc && wr_ok;
		cmd.wr_addr = count_q[crbw_pkg::AW-1:0];
		cmd.init = acc && last_point && ok;
		cmd.rd_en = (state_q == S_RD);
		cmd.rd_j = j_q;
		cmd.rd_k = k_q;
		cmd.mul_en = (state_q == S_MUL);
		cmd.sum_en = (state_q == S_SUM);
		cmd.diag = (j_q == k_q);
		cmd.pair_start = (state_q == S_AST);
		cmd.cmp_en = (state_q == S_CMP);
		cmd.first = first_q;
		cmd.fin_start = (state_q == S_FST);
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("result strobe longer than one cycle");
	a_no_write_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !cmd.wr_en) else $error("store written while computing");
	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr_en |-> (count_q < crbw_pkg::CW'(crbw_pkg::MAX_POINTS)))
		else $error("store written beyond its depth");
	a_result_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (state_q == S_IDLE)) else $error("result shown while busy");

endmodule

// ===== src/cluster_range_bearing_width_core.sv =====
// Lidar cluster summarizer. Points are written one word per accepted start (start high
// while busy is low) and are taken back to back during loading. On the word marked last
// the block checks the cluster size against max_span and, if it fits, goes busy and runs
// over all ordered point pairs, n*n pairs for n points: each pair takes a store read,
// multiply, sum, start and compare plus one pass of the shared arctangent unit
// (normalization, then 28 rotation steps), which finishes at once when the cross and dot
// products are both zero.
// A final arctangent pass for the bearing runs beside an 18-step square root.
// The result is shown for exactly one cycle with done; the receiver
// cannot hold it off, so it must take the word in that cycle. A skipped cluster gives
// no done and the block stays idle. max_span may be written only while idle.
module cluster_range_bearing_width_core (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cfg_we,
	input logic [crbw_pkg::SPAN_W-1:0] cfg_wdata,
	input logic signed [crbw_pkg::PW-1:0] point_x,
	input logic signed [crbw_pkg::PW-1:0] point_y,
	input logic last_point,
	output logic done,
	output logic [crbw_pkg::ROOT_W-1:0] min_range,
	output logic signed [crbw_pkg::BRG_W-1:0] bearing,
	output logic [crbw_pkg::WID_W-1:0] angular_width
);

	crbw_pkg::cmd_t cmd;
	crbw_pkg::sts_t sts;

	crbw_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.last_point(last_point),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.sts(sts),
		.cmd(cmd),
		.busy(busy),
		.done(done)
	);

	crbw_dp u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.point_x(point_x),
		.point_y(point_y),
		.min_range(min_range),
		.bearing(bearing),
		.angular_width(angular_width)
	);

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import crbw_pkg::*;

	localparam longint CYCLE_LIMIT = 6000000;
	localparam int SETTLE_CYCLES = 80;

	typedef struct {
		logic signed [PW-1:0] x;
		logic signed [PW-1:0] y;
		logic lst;
	} point_word_t;

	typedef struct {
		logic [ROOT_W-1:0] rng;
		logic signed [BRG_W-1:0] brg;
		logic [WID_W-1:0] wid;
	} summary_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic [SPAN_W-1:0] cfg_wdata = '0;
	logic signed [PW-1:0] point_x = '0;
	logic signed [PW-1:0] point_y = '0;
	logic last_point = 1'b0;
	logic done;
	logic [ROOT_W-1:0] min_range;
	logic signed [BRG_W-1:0] bearing;
	logic [WID_W-1:0] angular_width;

	cluster_range_bearing_width_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.point_x(point_x),
		.point_y(point_y),
		.last_point(last_point),
		.done(done),
		.min_range(min_range),
		.bearing(bearing),
		.angular_width(angular_width)
	);

	always #5 clk = ~clk;

	// Words waiting to be sent, and summaries waiting to come back.
	point_word_t point_q[$];
	summary_t summary_q[$];
	int words_pushed = 0;
	int words_taken = 0;
	int errors = 0;
	bit hold_sender = 1'b1;
	bit steady = 1'b0;
	bit took = 1'b0;
	longint cycles = 0;

	// Mirror of the block's point store and register.
	longint pts_x[MAX_POINTS];
	longint pts_y[MAX_POINTS];
	int pts_n = 0;
	bit pts_ovf = 1'b0;
	int span_cfg = 63;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Bit-exact vectoring arctangent, pi equal to 2^31, rounded to pi equal to 32768.
	function automatic int arc_angle(input longint y_in, input longint x_in);
		longint x, y, z, m, ax, ay, nx, tab;
		x = x_in;
		y = y_in;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? 64'sd2147483648 : -64'sd2147483648;
			x = -x;
			y = -y;
		end
		ax = x;
		ay = (y < 0) ? -y : y;
		m = (ax > ay) ? ax : ay;
		while (m < (64'sd1 <<< 40)) begin
			x = x * 2;
			y = y * 2;
			m = m * 2;
		end
		for (int i = 0; i < STEPS; i++) begin
			case (i)
				0: tab = 64'h20000000;
				1: tab = 64'h12E4051E;
				2: tab = 64'h09FB385B;
				3: tab = 64'h051111D4;
				4: tab = 64'h028B0D43;
				5: tab = 64'h0145D7E1;
				6: tab = 64'h00A2F61E;
				7: tab = 64'h00517C55;
				8: tab = 64'h0028BE53;
				9: tab = 64'h00145F2F;
				10: tab = 64'h000A2F98;
				11: tab = 64'h000517CC;
				12: tab = 64'h00028BE6;
				13: tab = 64'h000145F3;
				14: tab = 64'h0000A2FA;
				15: tab = 64'h0000517D;
				16: tab = 64'h000028BE;
				17: tab = 64'h0000145F;
				18: tab = 64'h00000A30;
				19: tab = 64'h00000518;
				20: tab = 64'h0000028C;
				21: tab = 64'h00000146;
				22: tab = 64'h000000A3;
				23: tab = 64'h00000051;
				24: tab = 64'h00000029;
				25: tab = 64'h00000014;
				26: tab = 64'h0000000A;
				default: tab = 64'h00000005;
			endcase
			if (y > 0) begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				x = nx;
				z = z + tab;
			end else if (y < 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				x = nx;
				z = z - tab;
			end
		end
		return int'((z + 32768) >>> 16);
	endfunction

	// Square root rounded to the nearest integer.
	function automatic longint round_root(input longint n);
		longint r;
		r = longint'($sqrt(real'(n)));
		while (r * r > n) r--;
		while ((r + 1) * (r + 1) <= n) r++;
		if (n - r * r > r) r++;
		return r;
	endfunction

	// Takes one point word; on a valid last word queues the cluster summary.
	task automatic absorb_point(input point_word_t w);
		longint best_sq, sq, bx, by;
		int best_ang, a, wid;
		bit have;
		summary_t s;
		if (pts_ovf || pts_n >= MAX_POINTS) begin
			pts_ovf = 1'b1;
		end else begin
			pts_x[pts_n] = longint'(w.x);
			pts_y[pts_n] = longint'(w.y);
			pts_n++;
		end
		if (!w.lst) return;
		if (pts_ovf || pts_n == 0 || pts_n - 1 > span_cfg) begin
			pts_n = 0;
			pts_ovf = 1'b0;
			return;
		end
		best_sq = 64'h7FFFFFFFFFFFFFFF;
		best_ang = 0;
		bx = 0;
		by = 0;
		have = 1'b0;
		for (int j = 0; j < pts_n; j++) begin
			sq = pts_x[j] * pts_x[j] + pts_y[j] * pts_y[j];
			if (sq < best_sq) best_sq = sq;
			for (int k = 0; k < pts_n; k++) begin
				a = arc_angle(pts_x[j] * pts_y[k] - pts_y[j] * pts_x[k],
					pts_x[j] * pts_x[k] + pts_y[j] * pts_y[k]);
				if (!have || a > best_ang) begin
					have = 1'b1;
					best_ang = a;
					bx = pts_x[j] + pts_x[k];
					by = pts_y[j] + pts_y[k];
				end
			end
		end
		wid = (best_ang < 0) ? 0 : ((best_ang > 32767) ? 32767 : best_ang);
		s.rng = ROOT_W'(round_root(best_sq));
		s.brg = BRG_W'(arc_angle(by, bx));
		s.wid = WID_W'(wid);
		summary_q.insert(summary_q.size(), s);
		pts_n = 0;
		pts_ovf = 1'b0;
	endtask

	// Monitor: accepts words and checks summaries at the rising edge.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
		took <= start && !busy && arst_n;
		if (start && !busy && arst_n) begin
			absorb_point('{x: point_x, y: point_y, lst: last_point});
			words_taken++;
		end
		if (done && arst_n) begin
			if (summary_q.size() == 0) begin
				report_mismatch("unexpected summary, range", longint'(min_range), -1);
			end else begin
				if (min_range !== summary_q[0].rng)
					report_mismatch("min_range", longint'(min_range),
						longint'(summary_q[0].rng));
				if (bearing !== summary_q[0].brg)
					report_mismatch("bearing", longint'(bearing),
						longint'(summary_q[0].brg));
				if (angular_width !== summary_q[0].wid)
					report_mismatch("angular_width", longint'(angular_width),
						longint'(summary_q[0].wid));
				void'(summary_q.pop_front());
			end
		end
	end

	// Driver: presents the next word at the falling edge, with random gaps.
	always @(negedge clk) begin
		point_word_t w;
		logic nxt_start;
		logic signed [PW-1:0] nx, ny;
		logic nl;
		nxt_start = start;
		nx = point_x;
		ny = point_y;
		nl = last_point;
		if (!start || took) begin
			nxt_start = 1'b0;
			if (!hold_sender && point_q.size() != 0 &&
				(steady || $urandom_range(99) >= 37)) begin
				w = point_q.pop_front();
				nxt_start = 1'b1;
				nx = w.x;
				ny = w.y;
				nl = w.lst;
			end
		end
		start <= nxt_start;
		point_x <= nx;
		point_y <= ny;
		last_point <= nl;
	end

	function automatic logic signed [PW-1:0] pick_coord();
		case ($urandom_range(7))
			0: return 18'sh1FFFF;
			1: return -18'sh20000;
			2: return '0;
			3: return $urandom_range(1) ? 18'sd1 : -18'sd1;
			4, 5: return PW'($urandom_range(2000)) - 18'sd1000;
			default: return PW'($urandom);
		endcase
	endfunction

	task automatic push_word(input logic signed [PW-1:0] x, input logic signed [PW-1:0] y,
		input logic lst);
		point_word_t w;
		w = '{x: x, y: y, lst: lst};
		point_q.insert(point_q.size(), w);
		words_pushed++;
	endtask

	task automatic push_cluster(input int n);
		for (int i = 0; i < n; i++) push_word(pick_coord(), pick_coord(), i == n - 1);
	endtask

	// Lets the sender run until all is taken, then holds it until answered and idle.
	task automatic drain();
		hold_sender = 1'b0;
		wait (words_taken == words_pushed);
		hold_sender = 1'b1;
		wait (summary_q.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
		wait (!busy);
	endtask

	task automatic write_span(input int v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= SPAN_W'(v);
		@(negedge clk);
		cfg_we <= 1'b0;
		span_cfg = v;
	endtask

	// Random clusters, mostly small, with some oversized ones that must be skipped.
	task automatic random_phase(input int words);
		int n;
		int sent;
		sent = 0;
		while (sent < words) begin
			if ($urandom_range(9) == 0) n = span_cfg + 2 + $urandom_range(2);
			else n = 1 + $urandom_range(5);
			if (n > MAX_POINTS + 1) n = MAX_POINTS + 1;
			push_cluster(n);
			sent += n;
		end
		drain();
	endtask

	initial begin
		int spans[4];
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed clusters with the register at its reset value.
		push_word(18'sh1FFFF, 18'sh1FFFF, 1'b1);
		push_word(-18'sh20000, -18'sh20000, 1'b1);
		push_word(18'sd0, 18'sd0, 1'b1);
		// Opposite points: widest angle saturates and the sum vector is zero.
		push_word(18'sd1000, 18'sd0, 1'b0);
		push_word(-18'sd1000, 18'sd0, 1'b1);
		// Collinear points tie on the angle; the first pair must be kept.
		push_word(18'sd100, 18'sd100, 1'b0);
		push_word(18'sd200, 18'sd200, 1'b0);
		push_word(18'sd300, 18'sd300, 1'b1);
		// A point at the origin among others, and a mixed-sign pair.
		push_word(18'sd0, 18'sd0, 1'b0);
		push_word(18'sd5, -18'sd7, 1'b0);
		push_word(-18'sh20000, 18'sh1FFFF, 1'b1);
		push_word(18'sh1FFFF, -18'sh20000, 1'b0);
		push_word(-18'sd1, 18'sd1, 1'b1);
		drain();

		// Smallest span: only single-point clusters give a summary.
		write_span(0);
		push_word(18'sd3, 18'sd4, 1'b1);
		push_word(18'sd3, 18'sd4, 1'b0);
		push_word(18'sd6, 18'sd8, 1'b1);
		push_word(-18'sd9, 18'sd12, 1'b1);
		drain();

		spans = '{63, 0, 5, 2};
		steady = 1'b1;
		write_span(spans[0]);
		random_phase(300);
		steady = 1'b0;
		for (int p = 1; p < 4; p++) begin
			write_span(spans[p]);
			random_phase(280);
		end
		write_span($urandom_range(63));
		random_phase(200);

		// Full store at the widest span, then one word past the store.
		write_span(63);
		push_cluster(MAX_POINTS);
		push_cluster(MAX_POINTS + 1);
		random_phase(250);

		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
src/crbw_pkg.sv
src/crbw_atan.sv
src/crbw_isqrt.sv
src/crbw_dp.sv
src/crbw_ctrl.sv
src/cluster_range_bearing_width_core.sv
tb/sv/tb_top.sv
